### design/fsp_pkg.sv
// Shared types, constants and character tables for the framed sensor packet parser.
// Used by fsp_framer and framed_sensor_packet_parser; depends on nothing else.
`timescale 1ns / 1ps

package fsp_pkg;

  localparam int NUM_SENSORS = 8;
  localparam int REC_W = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;
  localparam int CNT_W = $clog2(NUM_SENSORS + 1);
  localparam int BYTE_W = 8;
  localparam int VAL_W = 32;
  localparam int IDX_W = 3;
  localparam int POS_W = 3;

  localparam logic [POS_W-1:0] HDR_LAST = 3'd4;
  localparam logic [POS_W-1:0] REC_LAST = 3'd4;
  localparam logic [POS_W-1:0] FTR_LAST = 3'd2;
  localparam logic [REC_W-1:0] REC_MAX = REC_W'(NUM_SENSORS - 1);
  localparam logic [BYTE_W-1:0] CHAR_ZERO = 8'h30;

  typedef enum logic [1:0] {
    ST_HDR,
    ST_DATA,
    ST_FTR
  } state_t;

  typedef logic [NUM_SENSORS-1:0][VAL_W-1:0] store_t;

  typedef struct packed {
    logic done;
    logic busy;
  } frame_evt_t;

  function automatic logic [BYTE_W-1:0] hdr_char(input logic [POS_W-1:0] pos);
    logic [BYTE_W-1:0] c;
    unique case (pos)
      3'd0: c = 8'h73;
      3'd1: c = 8'h74;
      3'd2: c = 8'h61;
      3'd3: c = 8'h72;
      3'd4: c = 8'h74;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [BYTE_W-1:0] ftr_char(input logic [POS_W-1:0] pos);
    logic [BYTE_W-1:0] c;
    unique case (pos)
      3'd0: c = 8'h65;
      3'd1: c = 8'h6e;
      3'd2: c = 8'h64;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

### design/fsp_framer.sv
// Frame position tracker and value store for the framed sensor packet parser.
// Depends on fsp_pkg for the state type, character tables and store type.
`timescale 1ns / 1ps

module fsp_framer
  import fsp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              byte_fire,
  input  logic [BYTE_W-1:0] rx_byte,
  output frame_evt_t        evt,
  output store_t            store
);

  state_t            state_r, state_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [REC_W-1:0]  rec_r, rec_nxt;
  store_t            store_r;

  logic              match;
  logic              wr_en;
  logic [1:0]        lane;

  always_comb begin
    match = 1'b0;
    wr_en = 1'b0;
    lane  = 2'(pos_r - 3'd1);
    unique case (state_r)
      ST_HDR:  match = (rx_byte == hdr_char(pos_r));
      ST_DATA: begin
        if (pos_r == '0) begin
          match = (rx_byte == CHAR_ZERO + BYTE_W'(rec_r));
        end else begin
          match = 1'b1;
          wr_en = byte_fire;
        end
      end
      ST_FTR:  match = (rx_byte == ftr_char(pos_r));
      default: match = 1'b0;
    endcase
    evt.done = byte_fire && match && (state_r == ST_FTR) && (pos_r == FTR_LAST);
    evt.busy = (state_r == ST_FTR) && (pos_r == FTR_LAST);
  end

  always_comb begin
    state_nxt = state_r;
    pos_nxt   = pos_r;
    rec_nxt   = rec_r;
    if (byte_fire) begin
      if (!match) begin
        state_nxt = ST_HDR;
        pos_nxt   = '0;
        rec_nxt   = '0;
      end else begin
        unique case (state_r)
          ST_HDR: begin
            if (pos_r == HDR_LAST) begin
              state_nxt = ST_DATA;
              pos_nxt   = '0;
              rec_nxt   = '0;
            end else begin
              pos_nxt = pos_r + 3'd1;
            end
          end
          ST_DATA: begin
            if (pos_r == REC_LAST) begin
              pos_nxt = '0;
              if (rec_r == REC_MAX) begin
                state_nxt = ST_FTR;
                rec_nxt   = '0;
              end else begin
                rec_nxt = rec_r + REC_W'(1);
              end
            end else begin
              pos_nxt = pos_r + 3'd1;
            end
          end
          ST_FTR: begin
            if (pos_r == FTR_LAST) begin
              state_nxt = ST_HDR;
              pos_nxt   = '0;
            end else begin
              pos_nxt = pos_r + 3'd1;
            end
          end
          default: begin
            state_nxt = ST_HDR;
            pos_nxt   = '0;
            rec_nxt   = '0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_HDR;
      pos_r   <= '0;
      rec_r   <= '0;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
      rec_r   <= rec_nxt;
    end
  end

  // Every byte of every slot is rewritten within a frame before it is read out.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_r[rec_r][8*lane +: 8] <= rx_byte;
    end
  end

  assign store = store_r;

endmodule

### design/framed_sensor_packet_parser.sv
// Top level of the framed sensor packet parser: byte input, framing, result drain.
// Depends on fsp_pkg and fsp_framer.
`timescale 1ns / 1ps

// The block takes one received byte per word on the in_ channel and tracks its
// place in a frame: the header "start", eight records of an ASCII index digit
// and four value bytes (least significant first), then the footer "end".
// A byte that breaks the header, an index digit or the footer drops the
// partial frame and the parser waits for a new header.
// When the closing footer byte is accepted, the eight values are copied into
// an output buffer and presented on the out_ channel one word per cycle while
// out_ready is high, in index order, with out_last_value set on the eighth.
// Latency: the first result is valid in the cycle after the closing byte is
// accepted. Throughput: one input byte per cycle while in_ready is high; the
// frame's eight results drain while the next frame is already being received.
// If the receiver stalls, in_ready drops only while the parser waits for the
// closing footer byte and the previous frame's results are not all taken.
// Reset returns the parser to the header search and empties the output buffer.

module framed_sensor_packet_parser
  import fsp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [BYTE_W-1:0] in_rx_byte,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [IDX_W-1:0]  out_sensor_index,
  output logic [VAL_W-1:0]  out_sensor_value,
  output logic              out_last_value
);

  frame_evt_t       evt;
  store_t           store;
  store_t           buf_r;
  logic [REC_W-1:0] idx_r;
  logic [CNT_W-1:0] remain_r;
  logic             in_fire;
  logic             out_fire;

  assign in_ready = !(evt.busy && (remain_r != '0));
  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  fsp_framer u_framer (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_fire (in_fire),
    .rx_byte   (in_rx_byte),
    .evt       (evt),
    .store     (store)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      remain_r <= '0;
      idx_r    <= '0;
    end else if (evt.done) begin
      remain_r <= CNT_W'(NUM_SENSORS);
      idx_r    <= '0;
    end else if (out_fire) begin
      remain_r <= remain_r - CNT_W'(1);
      idx_r    <= idx_r + REC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (evt.done) begin
      buf_r <= store;
    end
  end

  assign out_valid        = (remain_r != '0);
  assign out_sensor_index = IDX_W'(idx_r);
  assign out_sensor_value = buf_r[idx_r];
  assign out_last_value   = (remain_r == CNT_W'(1));

`ifndef SYNTHESIS
  a_load_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    evt.done |-> (remain_r == '0))
    else $error("frame completed while results were still pending");

  a_last_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && out_last_value) |=> !out_valid)
    else $error("results remain after the last word was taken");

  a_drain_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && !out_last_value) |=> out_valid)
    else $error("result drain stopped before the last word");
`endif

endmodule
